// ===== src/dttm_pkg.sv =====
// Shared types, widths and helpers for the differential thrust trim mixer.
package dttm_pkg;

	localparam int MAX_POINTS_DEF = 8;
	localparam int FRAC_BITS      = 14;

	localparam int ENTRY_W = 32;
	localparam int FIELD_W = 16;
	localparam int DRIVE_W = 15;
	localparam int COUNT_W = 4;
	localparam int INDEX_W = 3;
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 32;

	// working width for sums of Q1.14 values and trim limits
	localparam int VAL_W  = 19;
	localparam int PROD_W = 2 * VAL_W;
	localparam int DEN_W  = 16;
	localparam int Q_W    = 17;

	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	localparam val_t ONE_V = val_t'(1 << FRAC_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_EXT,
		ST_SCAN_BRK,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_MIX   = 1'b1;

	function automatic val_t clamp_unit(input val_t v);
		val_t r;
		if (v < 0) begin
			r = '0;
		end else if (v > ONE_V) begin
			r = ONE_V;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== src/differential_thrust_trim_mixer.sv =====
// Differential thrust mixer with a piecewise-linear trim table: a write request stores a
// trim point; a mix request finishes without a scan when throttle is not positive or the
// table is empty, after one scan for the table's extremes when the throttle lies outside
// the table's range, else after a second scan for the bracket and, if its span is positive,
// a 17-step serial divider; each scan uses the table's single read port, one entry per cycle.
// A finished result waits in the output register while the next request is taken.
module differential_thrust_trim_mixer import dttm_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// rudder[66:51], throttle[50:35], point_trim[34:19], point_throttle[18:3],
	// point_index[2:0]; zero padded
	input  logic [S_DATA_W-1:0] s_tdata,
	// action[0]
	input  logic [0:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// right_drive[29:15], left_drive[14:0]; zero padded
	output logic [M_DATA_W-1:0] m_tdata,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [COUNT_W-1:0]  cfg_data
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	state_t state_q, state_d;

	logic [COUNT_W-1:0] count_q;
	logic [CW-1:0]      n_w;
	logic [CW-1:0]      cnt_q;
	logic               rd_vld_s1;
	logic               rd_first_s1;

	logic                     accept;
	logic                     in_action;
	logic [INDEX_W-1:0]       in_idx;
	logic signed [FIELD_W-1:0] in_pthr, in_ptrim, in_thr, in_rud;
	logic                     wr_en;
	logic [AW-1:0]            waddr;
	logic [ENTRY_W-1:0]       rdata;
	logic signed [FIELD_W-1:0] rd_thr, rd_trim;
	val_t                     rd_thr_v;

	val_t bl_d, br_d, t_d;
	val_t bl_q, br_q, t_q, trim_q;
	logic zero_q;
	logic signed [FIELD_W-1:0] lo_thr_q, lo_trim_q, hi_thr_q, hi_trim_q;
	logic signed [FIELD_W-1:0] a_thr_q, a_trim_q, b_thr_q, b_trim_q;
	prod_t            prod_q;
	logic [DEN_W-1:0] span_q;

	logic issue, drained, t_le_lo, t_ge_hi, span_pos, out_free, mix_zero;
	val_t span_w, dt, dtrim;
	logic div_start, div_done;
	val_t div_quot;

	val_t dlo_a, dlo_b, dlo, dhi_a, dhi_b, dhi, tl, tl_adj, half, l_v, r_v;
	logic m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	// request unpacking
	assign in_action = s_tuser[0];
	assign in_idx    = s_tdata[2:0];
	assign in_pthr   = s_tdata[18:3];
	assign in_ptrim  = s_tdata[34:19];
	assign in_thr    = s_tdata[50:35];
	assign in_rud    = s_tdata[66:51];

	assign accept    = s_tvalid & s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	assign n_w = ({28'd0, count_q} > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(count_q);

	assign wr_en = accept && (in_action == ACT_WRITE) && ({29'd0, in_idx} < 32'(MAX_POINTS));
	assign waddr = AW'(in_idx);

	dttm_table #(
		.DEPTH(MAX_POINTS),
		.AW   (AW)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata({in_pthr, in_ptrim}),
		.raddr(cnt_q[AW-1:0]),
		.rdata(rdata)
	);

	assign rd_thr   = rdata[31:16];
	assign rd_trim  = rdata[15:0];
	assign rd_thr_v = val_t'(rd_thr);

	assign bl_d     = clamp_unit(val_t'(in_thr) + val_t'(in_rud));
	assign br_d     = clamp_unit(val_t'(in_thr) - val_t'(in_rud));
	assign t_d      = clamp_unit(val_t'(in_thr));
	assign mix_zero = (in_thr <= 0);

	assign issue    = (state_q == ST_SCAN_EXT || state_q == ST_SCAN_BRK) && (cnt_q < n_w);
	assign drained  = (cnt_q == n_w) && !rd_vld_s1;
	assign t_le_lo  = t_q <= val_t'(lo_thr_q);
	assign t_ge_hi  = t_q >= val_t'(hi_thr_q);
	assign span_w   = val_t'(b_thr_q) - val_t'(a_thr_q);
	assign span_pos = span_w > 0;
	assign dt       = t_q - val_t'(a_thr_q);
	assign dtrim    = val_t'(b_trim_q) - val_t'(a_trim_q);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_action == ACT_MIX) begin
					state_d = (mix_zero || n_w == '0) ? ST_FINISH : ST_SCAN_EXT;
				end
			end
			ST_SCAN_EXT: begin
				if (drained) begin
					state_d = (t_le_lo || t_ge_hi) ? ST_FINISH : ST_SCAN_BRK;
				end
			end
			ST_SCAN_BRK: begin
				if (drained) begin
					state_d = span_pos ? ST_MUL : ST_FINISH;
				end
			end
			ST_MUL: begin
				state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (accept || (state_q == ST_SCAN_EXT && drained)) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			rd_vld_s1 <= issue;
			if (state_q == ST_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	dttm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (prod_q),
		.den   (span_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	// datapath: scans over the table, bracket selection, trim capture
	always_ff @(posedge clk) begin
		rd_first_s1 <= issue && (cnt_q == '0);
		if (accept && in_action == ACT_MIX) begin
			bl_q   <= bl_d;
			br_q   <= br_d;
			t_q    <= t_d;
			zero_q <= mix_zero;
			trim_q <= '0;
		end
		if (state_q == ST_SCAN_EXT && rd_vld_s1) begin
			// later slots win ties
			if (rd_first_s1 || rd_thr_v <= val_t'(lo_thr_q)) begin
				lo_thr_q  <= rd_thr;
				lo_trim_q <= rd_trim;
			end
			if (rd_first_s1 || rd_thr_v >= val_t'(hi_thr_q)) begin
				hi_thr_q  <= rd_thr;
				hi_trim_q <= rd_trim;
			end
		end
		if (state_q == ST_SCAN_EXT && drained) begin
			if (t_le_lo) begin
				trim_q <= val_t'(lo_trim_q);
			end else if (t_ge_hi) begin
				trim_q <= val_t'(hi_trim_q);
			end
			a_thr_q  <= lo_thr_q;
			a_trim_q <= lo_trim_q;
			b_thr_q  <= hi_thr_q;
			b_trim_q <= hi_trim_q;
		end
		if (state_q == ST_SCAN_BRK && rd_vld_s1) begin
			if (rd_thr_v <= t_q && rd_thr_v >= val_t'(a_thr_q)) begin
				a_thr_q  <= rd_thr;
				a_trim_q <= rd_trim;
			end
			if (rd_thr_v >= t_q && rd_thr_v <= val_t'(b_thr_q)) begin
				b_thr_q  <= rd_thr;
				b_trim_q <= rd_trim;
			end
		end
		if (state_q == ST_SCAN_BRK && drained && !span_pos) begin
			trim_q <= val_t'(a_trim_q);
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_t'(dt) * prod_t'(dtrim);
			span_q <= span_w[DEN_W-1:0];
		end
		if (state_q == ST_DIV_WAIT && div_done) begin
			trim_q <= val_t'(a_trim_q) + div_quot;
		end
		if (state_q == ST_FINISH && out_free) begin
			m_tdata_q <= zero_q ? '0 : {2'b00, r_v[DRIVE_W-1:0], l_v[DRIVE_W-1:0]};
		end
	end

	// limit the trim so it never clips the pilot command further
	assign dlo_a  = (bl_q - ONE_V) <<< 1;
	assign dlo_b  = -(br_q <<< 1);
	assign dlo    = (dlo_a > dlo_b) ? dlo_a : dlo_b;
	assign dhi_a  = bl_q <<< 1;
	assign dhi_b  = (ONE_V - br_q) <<< 1;
	assign dhi    = (dhi_a < dhi_b) ? dhi_a : dhi_b;
	assign tl     = (trim_q < dlo) ? dlo : ((trim_q > dhi) ? dhi : trim_q);
	assign tl_adj = tl + val_t'(tl[VAL_W-1]);
	assign half   = tl_adj >>> 1;
	assign l_v    = clamp_unit(bl_q - half);
	assign r_v    = clamp_unit(br_q + half);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[14:0] <= 15'(ONE_V)) && (m_tdata[29:15] <= 15'(ONE_V)))
		else $error("drive above full scale");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN_EXT || state_q == ST_SCAN_BRK))
		else $error("table read returned outside a scan");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> $past(state_q) == ST_DIV_WAIT && state_q == ST_DIV_WAIT)
		else $error("divider finished with no division pending");

	a_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> (val_t'(a_thr_q) < t_q || val_t'(a_thr_q) == t_q)
			&& (t_q < val_t'(b_thr_q) || t_q == val_t'(b_thr_q)))
		else $error("bracket does not enclose throttle");

endmodule

// ===== src/dttm_table.sv =====
// Trim point table: one write port, one read port with registered read data.
module dttm_table import dttm_pkg::*; #(
	parameter int DEPTH = MAX_POINTS_DEF,
	parameter int AW    = $clog2(MAX_POINTS_DEF)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [ENTRY_W-1:0] wdata,
	input  logic [AW-1:0]      raddr,
	output logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== src/dttm_div.sv =====
// Serial restoring divider for the interpolation quotient, one bit per cycle.
module dttm_div import dttm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  prod_t            num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output val_t             quot
);

	localparam int SW = $clog2(Q_W);

	logic             busy_q;
	logic             done_q;
	logic [SW-1:0]    step_q;
	logic [DEN_W:0]   rem_q;
	logic [Q_W-1:0]   quo_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;

	logic [PROD_W-1:0] mag;
	logic [DEN_W:0]    trial;
	logic              fits;
	val_t              qpos;

	assign mag   = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
	assign trial = {rem_q[DEN_W-1:0], quo_q[Q_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient is known to fit Q_W bits, so the top of the dividend is below den
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (DEN_W+1)'(mag >> Q_W);
			quo_q <= mag[Q_W-1:0];
			den_q <= den;
			neg_q <= num[PROD_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[Q_W-2:0], fits};
		end
	end

	assign qpos = val_t'(quo_q);
	assign quot = neg_q ? -qpos : qpos;
	assign done = done_q;

endmodule
